@@ design/biq_pkg.sv @@
// Shared definitions for the second-order IIR section.
// Holds register indexes, fixed-point constants and the divider status type.
// Used by second_order_iir_section and biq_div.
package biq_pkg;

  localparam int COEF_COUNT = 6;
  localparam int COEF_W     = 32;
  localparam int SAMPLE_W   = 32;
  localparam int INDEX_W    = 3;
  localparam int COEF_FRAC  = 28;

  localparam logic [INDEX_W-1:0] IX_B0 = 3'd0;
  localparam logic [INDEX_W-1:0] IX_B1 = 3'd1;
  localparam logic [INDEX_W-1:0] IX_B2 = 3'd2;
  localparam logic [INDEX_W-1:0] IX_A0 = 3'd3;
  localparam logic [INDEX_W-1:0] IX_A1 = 3'd4;
  localparam logic [INDEX_W-1:0] IX_A2 = 3'd5;

  localparam logic [COEF_W-1:0] A0_RESET = 32'h1000_0000;

  // Dividend magnitude is 64 bits; only 33 quotient bits matter for saturation.
  localparam int DIVIDEND_W = 64;
  localparam int QUOT_W     = 33;
  localparam int DIV_CNT_W  = 6;

  typedef struct packed {
    logic done;      // one-cycle pulse, quotient is valid
    logic too_big;   // quotient is at least 2**QUOT_W
  } biq_div_stat_t;

endpackage

@@ design/biq_div.sv @@
// Bit-serial restoring divider for the IIR section, one quotient bit a cycle.
// Produces the low 33 quotient bits and a flag when the quotient is larger.
// Depends on biq_pkg.
module biq_div
  import biq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [COEF_W-1:0]     divisor,
  output biq_div_stat_t         stat,
  output logic [QUOT_W-1:0]     quotient
);

  logic [COEF_W-1:0]    rem;
  logic [QUOT_W-1:0]    shreg;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic                 done;
  logic                 big;

  logic [DIVIDEND_W-QUOT_W-1:0] hi;
  logic [COEF_W:0]              trial;
  logic [COEF_W:0]              diff;
  logic                         ge;
  logic                         hi_big;

  assign hi     = dividend[DIVIDEND_W-1:QUOT_W];
  assign hi_big = {{(COEF_W+1-(DIVIDEND_W-QUOT_W)){1'b0}}, hi} >= {1'b0, divisor};
  assign trial  = {rem, shreg[QUOT_W-1]};
  assign ge     = trial >= {1'b0, divisor};
  assign diff   = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      big  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        big <= hi_big;
        if (hi_big) begin
          done <= 1'b1;
          run  <= 1'b0;
        end else begin
          run <= 1'b1;
          cnt <= DIV_CNT_W'(QUOT_W);
        end
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder always stays below the divisor, so it fits in 32 bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {{(COEF_W-(DIVIDEND_W-QUOT_W)){1'b0}}, hi};
      shreg <= dividend[QUOT_W-1:0];
    end else if (run) begin
      rem   <= ge ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
      shreg <= {shreg[QUOT_W-2:0], ge};
    end
  end

  assign quotient     = shreg;
  assign stat.done    = done;
  assign stat.too_big = big;

endmodule

@@ design/second_order_iir_section.sv @@
// Second-order IIR section, direct form II, Q16.16 samples, Q4.28 coefficients.
// Each sample takes five passes through the shared 32x32 multiplier and the sums,
// with the serial divider between the feedback and output passes. The divider
// stops early when the quotient overflows, and a zero coef_a0 skips to the result.
// A new sample is taken only after the last result has gone to the output register.
// Reset (rst, synchronous): delay line cleared, coefficients to zero, a0 to 1.0.
module second_order_iir_section
  import biq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] sample_out,
  output logic                overflow,
  output logic                zero_divisor
);

  localparam int ACC_W = 66;
  localparam int YMAG_W = ACC_W - COEF_FRAC;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_M1     = 4'd1;
  localparam logic [3:0] ST_M2     = 4'd2;
  localparam logic [3:0] ST_M3     = 4'd3;
  localparam logic [3:0] ST_DSTART = 4'd4;
  localparam logic [3:0] ST_DWAIT  = 4'd5;
  localparam logic [3:0] ST_WSET   = 4'd6;
  localparam logic [3:0] ST_Y1     = 4'd7;
  localparam logic [3:0] ST_Y2     = 4'd8;
  localparam logic [3:0] ST_Y3     = 4'd9;
  localparam logic [3:0] ST_Y4     = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;

  logic [3:0] state;

  logic [COEF_W-1:0]   coef_b0, coef_b1, coef_b2, coef_a0, coef_a1, coef_a2;
  logic [SAMPLE_W-1:0] delay_one, delay_two;
  logic [SAMPLE_W-1:0] w_reg;
  logic                w_sat;
  logic                zd;
  logic                num_neg;

  logic signed [ACC_W-1:0] acc;
  logic signed [63:0]      prod;

  logic [COEF_W-1:0]   mul_a;
  logic [SAMPLE_W-1:0] mul_b;
  logic                acc_sub;
  logic [ACC_W-1:0]    prod_ext;
  logic [ACC_W-1:0]    acc_next;
  logic [ACC_W-1:0]    acc_mag;

  logic                div_start;
  biq_div_stat_t       div_stat;
  logic [QUOT_W-1:0]   quot;
  logic [COEF_W-1:0]   a0_mag;

  logic                q_neg;
  logic                q_sat;
  logic [SAMPLE_W-1:0] w_val;

  logic [YMAG_W-1:0]   ymag;
  logic                yneg;
  logic                ysat;
  logic [SAMPLE_W-1:0] y_val;
  logic                out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a0 <= A0_RESET;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        IX_B0:   coef_b0 <= cfg_data;
        IX_B1:   coef_b1 <= cfg_data;
        IX_B2:   coef_b2 <= cfg_data;
        IX_A0:   coef_a0 <= cfg_data;
        IX_A1:   coef_a1 <= cfg_data;
        IX_A2:   coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = coef_a1;
    mul_b = delay_one;
    unique case (state)
      ST_M1:   begin mul_a = coef_a1; mul_b = delay_one; end
      ST_M2:   begin mul_a = coef_a2; mul_b = delay_two; end
      ST_Y1:   begin mul_a = coef_b0; mul_b = w_reg;     end
      ST_Y2:   begin mul_a = coef_b1; mul_b = delay_one; end
      ST_Y3:   begin mul_a = coef_b2; mul_b = delay_two; end
      default: ;
    endcase
  end

  // The numerator terms are subtracted, the output terms added.
  assign acc_sub  = (state == ST_M2) || (state == ST_M3);
  assign prod_ext = {{(ACC_W-64){prod[63]}}, prod};
  assign acc_next = acc_sub ? (ACC_W'(acc) - prod_ext) : (ACC_W'(acc) + prod_ext);
  assign acc_mag  = acc[ACC_W-1] ? (ACC_W'(0) - ACC_W'(acc)) : ACC_W'(acc);

  assign a0_mag    = coef_a0[COEF_W-1] ? (COEF_W'(0) - coef_a0) : coef_a0;
  assign div_start = (state == ST_DSTART);

  biq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag[DIVIDEND_W-1:0]),
    .divisor  (a0_mag),
    .stat     (div_stat),
    .quotient (quot)
  );

  // Quotient to saturated w.
  always_comb begin
    q_neg = num_neg && (quot != '0) && !div_stat.too_big;
    if (div_stat.too_big) begin
      q_neg = num_neg;
      q_sat = 1'b1;
    end else if (q_neg) begin
      q_sat = quot > QUOT_W'(33'h0_8000_0000);
    end else begin
      q_sat = quot > QUOT_W'(33'h0_7FFF_FFFF);
    end
    if (q_sat) begin
      w_val = q_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      w_val = q_neg ? (SAMPLE_W'(0) - quot[SAMPLE_W-1:0]) : quot[SAMPLE_W-1:0];
    end
  end

  // Output sum to Q16.16, truncated toward zero, then saturated.
  always_comb begin
    ymag = acc_mag[ACC_W-1:COEF_FRAC];
    yneg = acc[ACC_W-1] && (ymag != '0);
    ysat = yneg ? (ymag > YMAG_W'(33'h0_8000_0000)) : (ymag > YMAG_W'(33'h0_7FFF_FFFF));
    if (ysat) begin
      y_val = yneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      y_val = yneg ? (SAMPLE_W'(0) - ymag[SAMPLE_W-1:0]) : ymag[SAMPLE_W-1:0];
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= (coef_a0 == '0) ? ST_FIN : ST_M1;
          end
        end
        ST_M1:     state <= ST_M2;
        ST_M2:     state <= ST_M3;
        ST_M3:     state <= ST_DSTART;
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_stat.done) begin
            state <= ST_WSET;
          end
        end
        ST_WSET:   state <= ST_Y1;
        ST_Y1:     state <= ST_Y2;
        ST_Y2:     state <= ST_Y3;
        ST_Y3:     state <= ST_Y4;
        ST_Y4:     state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (!zd) begin
              delay_two <= delay_one;
              delay_one <= w_reg;
            end
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= $signed(mul_a) * $signed(mul_b);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          acc <= {{(ACC_W-SAMPLE_W-COEF_FRAC){sample_in[SAMPLE_W-1]}}, sample_in,
                  {COEF_FRAC{1'b0}}};
          zd  <= (coef_a0 == '0);
        end
      end
      ST_M2, ST_M3, ST_Y3, ST_Y4: acc <= $signed(acc_next);
      ST_DSTART: num_neg <= acc[ACC_W-1] ^ coef_a0[COEF_W-1];
      ST_DWAIT: begin
        if (div_stat.done) begin
          w_reg <= w_val;
          w_sat <= q_sat;
        end
      end
      ST_WSET: acc <= '0;
      ST_Y2:   acc <= $signed(acc_next);
      ST_FIN: begin
        if (out_free) begin
          if (zd) begin
            sample_out   <= '0;
            overflow     <= 1'b0;
            zero_divisor <= 1'b1;
          end else begin
            sample_out   <= y_val;
            overflow     <= w_sat | ysat;
            zero_divisor <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/biq_check.sv @@
// Port-level checker for second_order_iir_section, attached by bind.
// Depends on biq_pkg for widths.
module biq_check
  import biq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SAMPLE_W-1:0] sample_out,
  input logic                overflow,
  input logic                zero_divisor
);

  // A sample is worked on alone: the input side closes right after a transfer.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a sample is in progress");

  a_zero_div_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor) |-> (sample_out == '0 && !overflow))
    else $error("zero divisor result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_out)
                                   && $stable(overflow) && $stable(zero_divisor)))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("outputs active after reset");

endmodule

bind second_order_iir_section biq_check u_biq_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sample_out   (sample_out),
  .overflow     (overflow),
  .zero_divisor (zero_divisor)
);

@@ tb/sv/second_order_iir_section_tb.sv @@
// Self-checking testbench for second_order_iir_section, the direct form II biquad.
// Holds a bit-exact predictor of the section, the stimulus tests and the result checker.
// Depends on biq_pkg for register indexes and widths, and on the block's RTL.
`timescale 1ns / 100ps

module second_order_iir_section_tb;
  import biq_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                ovf;
    logic                zdiv;
  } filt_result_t;

  typedef enum int {PROF_GENTLE, PROF_WILD, PROF_CORNER, PROF_TINY_A0, PROF_NO_DIVISOR}
    coef_profile_t;

  localparam logic [INDEX_W-1:0] IX_SPARE_LO = 3'd6;
  localparam logic [INDEX_W-1:0] IX_SPARE_HI = 3'd7;
  localparam logic [COEF_W-1:0]  COEF_UNITY  = 32'h1000_0000;
  localparam logic [31:0]        S_MAX       = 32'h7fff_ffff;
  localparam logic [31:0]        S_MIN       = 32'h8000_0000;
  localparam logic signed [71:0] Q16_MAX     = 72'sd2147483647;
  localparam logic signed [71:0] Q16_MIN     = -72'sd2147483648;
  localparam logic signed [71:0] Q28_SCALE   = 72'sd268435456;
  localparam int QUIET_LIMIT   = 1500;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 40;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_write    = 1'b0;
  logic [INDEX_W-1:0]  cfg_index    = '0;
  logic [COEF_W-1:0]   cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample_in    = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [SAMPLE_W-1:0] sample_out;
  logic                overflow;
  logic                zero_divisor;

  // Predictor state: coefficients in register order and the two delay elements.
  logic signed [31:0] coef [COEF_COUNT] = '{32'sd0, 32'sd0, 32'sd0, A0_RESET, 32'sd0, 32'sd0};
  logic signed [31:0] delay_w1 = '0;
  logic signed [31:0] delay_w2 = '0;

  filt_result_t pending_results [$];
  filt_result_t due;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int in_calm      = 0;
  int out_calm     = 0;
  int stall_run    = 0;
  int free_run     = 0;
  logic [31:0] corner_coefs [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                    32'h1000_0000, 32'h0000_0001, 32'hffff_ffff};

  second_order_iir_section u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .overflow     (overflow),
    .zero_divisor (zero_divisor)
  );

  always #4 clk = ~clk;

  function automatic logic signed [31:0] clamp_q16(input logic signed [71:0] v,
                                                   output logic hit);
    hit = 1'b0;
    if (v > Q16_MAX) begin
      hit = 1'b1;
      return S_MAX;
    end
    if (v < Q16_MIN) begin
      hit = 1'b1;
      return S_MIN;
    end
    return v[31:0];
  endfunction

  // All sums are exact in 72 bits; signed division truncates toward zero as the block does.
  function automatic filt_result_t biquad_predict(input logic signed [31:0] x);
    logic signed [71:0] k [COEF_COUNT];
    logic signed [71:0] xs, d1, d2, ws, num;
    logic signed [31:0] w;
    logic hit_w, hit_y;
    filt_result_t r;
    r = '0;
    if (coef[IX_A0] == 0) begin
      r.zdiv = 1'b1;
      return r;
    end
    for (int i = 0; i < COEF_COUNT; i++) k[i] = coef[i];
    xs = x;
    d1 = delay_w1;
    d2 = delay_w2;
    num = (xs <<< COEF_FRAC) - k[IX_A1] * d1 - k[IX_A2] * d2;
    w = clamp_q16(num / k[IX_A0], hit_w);
    ws = w;
    num = k[IX_B0] * ws + k[IX_B1] * d1 + k[IX_B2] * d2;
    r.sample = clamp_q16(num / Q28_SCALE, hit_y);
    r.ovf = hit_w | hit_y;
    delay_w2 = delay_w1;
    delay_w1 = w;
    return r;
  endfunction

  // Mostly short pauses, some long ones, and now and then a stretch with none.
  function automatic int pause_len(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $urandom();
    if (pick < 85) return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    return corner_coefs[$urandom_range(0, 5)];
  endfunction

  function automatic coef_profile_t pick_profile();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return PROF_GENTLE;
    if (pick < 6) return PROF_WILD;
    if (pick < 8) return PROF_CORNER;
    if (pick < 9) return PROF_TINY_A0;
    return PROF_NO_DIVISOR;
  endfunction

  function automatic logic [31:0] pick_coef(input coef_profile_t prof, input logic divisor);
    int v;
    v = int'($urandom_range(0, 1 << 30)) - (1 << 29);
    case (prof)
      PROF_WILD: begin
        v = $urandom();
      end
      PROF_CORNER: begin
        v = corner_coefs[$urandom_range(0, 5)];
      end
      PROF_GENTLE: begin
        if (divisor) v = $urandom_range(1 << 27, 1 << 29);
      end
      PROF_TINY_A0: begin
        if (divisor) v = $urandom_range(1, 4096);
      end
      PROF_NO_DIVISOR: begin
        if (divisor) v = 0;
      end
      default: ;
    endcase
    if (divisor && prof != PROF_WILD && prof != PROF_CORNER && $urandom_range(0, 3) == 0)
      v = -v;
    return v;
  endfunction

  task automatic write_coef(input logic [INDEX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx < COEF_COUNT) coef[idx] = data;
  endtask

  task automatic load_coefs(input logic [31:0] b0, b1, b2, a0, a1, a2);
    write_coef(IX_B0, b0);
    write_coef(IX_B1, b1);
    write_coef(IX_B2, b2);
    write_coef(IX_A0, a0);
    write_coef(IX_A1, a1);
    write_coef(IX_A2, a2);
  endtask

  task automatic send_sample(input logic [31:0] x);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(biquad_predict(x));
    gap = pause_len(in_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Coefficients are only written once every outstanding result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic test_reset_coefs();
    // With the numerator cleared the output is zero, but w = x still fills the delay line.
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(32'h0000_0001);
  endtask

  task automatic test_passthrough();
    settle();
    load_coefs(COEF_UNITY, 32'h0, 32'h0, COEF_UNITY, 32'h0, 32'h0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(32'h0);
    send_sample(32'hffff_ffff);
  endtask

  task automatic test_saturation();
    settle();
    load_coefs(S_MAX, 32'h0, 32'h0, COEF_UNITY, 32'h0, 32'h0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    // The smallest divisor drives w itself into saturation.
    settle();
    load_coefs(COEF_UNITY, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0);
    send_sample(32'h0000_0100);
    send_sample(32'hffff_ff00);
    // Most negative divisor with extreme feedback and numerator terms.
    settle();
    load_coefs(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX);
    send_sample(32'h0);
    send_sample(S_MAX);
  endtask

  task automatic test_zero_divisor();
    settle();
    load_coefs(COEF_UNITY, COEF_UNITY, COEF_UNITY, 32'h0, 32'h0800_0000, 32'hf800_0000);
    send_sample(S_MAX);
    send_sample(32'h1234_5678);
    send_sample(S_MIN);
    // The delay line must have been held while the divisor was zero.
    settle();
    write_coef(IX_A0, COEF_UNITY);
    send_sample(32'h0001_0000);
    send_sample(32'h0);
  endtask

  task automatic test_spare_index();
    settle();
    load_coefs(COEF_UNITY, 32'h0, 32'h0, COEF_UNITY, 32'h0, 32'h0);
    write_coef(IX_SPARE_LO, S_MIN);
    write_coef(IX_SPARE_HI, S_MAX);
    send_sample(32'h0003_0000);
  endtask

  task automatic test_random_phases();
    coef_profile_t prof;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      prof = pick_profile();
      for (int j = 0; j < COEF_COUNT; j++)
        write_coef(INDEX_W'(j), pick_coef(prof, j == IX_A0));
      if ($urandom_range(0, 2) == 0)
        write_coef($urandom_range(0, 1) ? IX_SPARE_LO : IX_SPARE_HI, $urandom());
      repeat (PHASE_ITEMS) send_sample(pick_sample());
    end
  endtask

  always @(negedge clk) begin
    if (stall_run > 0) stall_run--;
    else if (free_run > 0) free_run--;
    else begin
      stall_run = pause_len(out_calm);
      free_run  = $urandom_range(0, 8);
    end
    out_stall <= (stall_run > 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, sample_out %h", $time, sample_out);
      end else begin
        due = pending_results.pop_front();
        if (sample_out !== due.sample) begin
          mismatches++;
          $display("%0t: sample_out expected %h, got %h", $time, due.sample, sample_out);
        end
        if (overflow !== due.ovf) begin
          mismatches++;
          $display("%0t: overflow expected %b, got %b", $time, due.ovf, overflow);
        end
        if (zero_divisor !== due.zdiv) begin
          mismatches++;
          $display("%0t: zero_divisor expected %b, got %b", $time, due.zdiv, zero_divisor);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_coefs();
    test_passthrough();
    test_saturation();
    test_zero_divisor();
    test_spare_index();
    test_random_phases();
    settle();
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
